[rtl/assert_macros.svh]
// Assertion macros used by the top level of the FIR filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked at every rising edge outside reset.
`define FWB_ASSERT_IMP(lbl, c, r, ante, cons) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication checked at every rising edge outside reset.
`define FWB_ASSERT_NXT(lbl, c, r, ante, cons) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

[rtl/fwb_pkg.sv]
// Package with the types, constants and codes of the FIR filter with bias.
`timescale 1ns / 1ps

package fwb_pkg;

    localparam int DW            = 24;
    localparam int FRAC_W        = 23;
    localparam int PROD_W        = 2 * DW;
    localparam int TAP_CNT_W     = 9;
    localparam int TAP_IDX_W     = 8;
    localparam int CH_W          = 1;
    localparam int REG_IDX_W     = 1;
    localparam int IN_DATA_W     = 56;
    localparam int IN_USER_W     = 2;
    localparam int TAP_DEPTH_DEF = 256;
    localparam int CHANNELS_DEF  = 2;
    localparam int Q_MAX         = 8388607;
    localparam int Q_MIN         = -8388608;

    localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = 9'd256;

    localparam logic [REG_IDX_W-1:0] REG_TAP_COUNT = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_BIAS      = 1'b1;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef struct packed {
        logic push;
        logic rotate;
    } fwb_cell_ctrl_t;

    typedef struct packed {
        logic start;
        logic mult_valid;
        logic round_en;
    } fwb_mac_ctrl_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RUN   = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_ROUND = 5'b01000,
        ST_EMIT  = 5'b10000
    } fwb_state_t;

endpackage

[rtl/fir_filter_with_bias_top.sv]
// Top level of the multi-channel direct-form FIR filter with bias.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A tap-load beat writes one coefficient into the cell at its index. A sample
// beat shifts the sample into its channel's delay line at acceptance, then the
// cell chain rotates once through all TAP_DEPTH cells while a single
// multiply-accumulate unit at cell zero sums the products. The input then stays
// stalled through the run, drain, round and emit states, and longer while the
// previous result still waits in the output register. The result is rounded to
// Q1.23 with ties toward plus infinity and saturated. Delay lines clear to zero
// at reset; taps must be loaded before samples are sent.

module fir_filter_with_bias_top
    import fwb_pkg::*;
#(
    parameter int TAP_DEPTH = TAP_DEPTH_DEF,
    parameter int CHANNELS  = CHANNELS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // sample, tap_index, tap_value
    input  logic [IN_USER_W-1:0]   s_tuser,   // opcode, channel
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [DW-1:0]          m_tdata,   // filtered_sample
    output logic [CH_W-1:0]        m_tuser,   // out_channel
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [REG_IDX_W-1:0]   cfg_index,
    input  logic [DW-1:0]          cfg_data
);

    localparam int CNT_W = $clog2(TAP_DEPTH + 1);

    fwb_state_t               state_reg;
    fwb_state_t               state_next;
    logic [CNT_W-1:0]         k_reg;
    logic [CNT_W-1:0]         k_next;
    logic [CHANNELS-1:0]      ch_sel_reg;
    logic [CHANNELS-1:0]      ch_sel_in;
    logic [CHANNELS-1:0]      ch_sel;
    logic [CH_W-1:0]          ch_reg;
    logic                     end_reg;
    logic [TAP_CNT_W-1:0]     tap_count_reg;
    logic signed [DW-1:0]     bias_reg;
    logic                     m_valid_reg;
    logic [DW-1:0]            m_data_reg;
    logic [CH_W-1:0]          m_user_reg;
    logic                     m_last_reg;

    logic                     in_opcode;
    logic [CH_W-1:0]          in_channel;
    logic signed [DW-1:0]     in_sample;
    logic [TAP_IDX_W-1:0]     in_tap_index;
    logic signed [DW-1:0]     in_tap_value;

    logic                     s_acc;
    logic                     ch_ok;
    logic                     do_push;
    logic                     do_load;
    logic                     out_free;

    fwb_cell_ctrl_t           cell_ctrl;
    fwb_mac_ctrl_t            mac_ctrl;
    logic signed [DW-1:0]     delay_out [TAP_DEPTH];
    logic signed [DW-1:0]     tap_out   [TAP_DEPTH];
    logic signed [DW-1:0]     mac_result;

    assign in_opcode    = s_tuser[0];
    assign in_channel   = s_tuser[1];
    assign in_sample    = s_tdata[23:0];
    assign in_tap_index = s_tdata[31:24];
    assign in_tap_value = s_tdata[55:32];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign ch_ok    = (32'(in_channel) < CHANNELS);
    assign do_push  = s_acc && (in_opcode == OP_SAMPLE) && ch_ok;
    assign do_load  = s_acc && (in_opcode == OP_LOAD);
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            ch_sel_in[c] = (32'(in_channel) == c);
        end
    end

    assign ch_sel = (state_reg == ST_IDLE) ? ch_sel_in : ch_sel_reg;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                k_next = '0;
                if (do_push)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                k_next = k_reg + CNT_W'(1);
                if (k_reg == CNT_W'(TAP_DEPTH - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cell_ctrl.push   = do_push;
    assign cell_ctrl.rotate = (state_reg == ST_RUN);

    assign mac_ctrl.start      = do_push;
    assign mac_ctrl.mult_valid = (state_reg == ST_RUN)
                                 && (32'(k_reg) < 32'(tap_count_reg));
    assign mac_ctrl.round_en   = (state_reg == ST_ROUND);

    for (genvar k = 0; k < TAP_DEPTH; k++)
    begin : g_cell
        logic signed [DW-1:0] prev_delay;
        logic                 tap_we;

        if (k == 0)
        begin : g_head
            assign prev_delay = in_sample;
        end
        else
        begin : g_body
            assign prev_delay = delay_out[k-1];
        end

        assign tap_we = do_load && ({24'd0, in_tap_index} == 32'(k));

        fwb_cell #(
            .CHANNELS (CHANNELS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .ch_sel     (ch_sel),
            .tap_we     (tap_we),
            .tap_load   (in_tap_value),
            .prev_delay (prev_delay),
            .next_delay (delay_out[(k + 1) % TAP_DEPTH]),
            .next_tap   (tap_out[(k + 1) % TAP_DEPTH]),
            .delay_out  (delay_out[k]),
            .tap_out    (tap_out[k])
        );
    end

    fwb_mac #(
        .TAP_DEPTH (TAP_DEPTH)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .bias   (bias_reg),
        .tap    (tap_out[0]),
        .delay  (delay_out[0]),
        .result (mac_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            ch_sel_reg    <= '0;
            tap_count_reg <= TAP_COUNT_RST;
            bias_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (do_push)
            begin
                ch_sel_reg <= ch_sel_in;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TAP_COUNT: tap_count_reg <= cfg_data[TAP_CNT_W-1:0];
                    REG_BIAS:      bias_reg      <= cfg_data;
                    default:       tap_count_reg <= tap_count_reg;
                endcase
            end
            if (state_reg == ST_EMIT && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ch_reg  <= in_channel;
            end_reg <= s_tlast;
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            m_data_reg <= mac_result;
            m_user_reg <= ch_reg;
            m_last_reg <= end_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    `FWB_ASSERT_IMP(a_run_onehot_ch, clk, rst_n, state_reg == ST_RUN, $onehot(ch_sel_reg))
    `FWB_ASSERT_NXT(a_emit_holds, clk, rst_n,
                    state_reg == ST_EMIT && m_valid_reg && !m_tready, state_reg == ST_EMIT)
    `FWB_ASSERT_IMP(a_out_from_emit, clk, rst_n,
                    $rose(m_valid_reg), $past(state_reg) == ST_EMIT)
    `FWB_ASSERT_NXT(a_push_starts_run, clk, rst_n,
                    do_push, state_reg == ST_RUN && k_reg == '0)

endmodule

[rtl/fwb_cell.sv]
// One cell of the delay-line chain: one delay word per channel and one tap weight.
`timescale 1ns / 1ps

module fwb_cell
    import fwb_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  fwb_cell_ctrl_t        ctrl,
    input  logic [CHANNELS-1:0]   ch_sel,
    input  logic                  tap_we,
    input  logic signed [DW-1:0]  tap_load,
    input  logic signed [DW-1:0]  prev_delay,
    input  logic signed [DW-1:0]  next_delay,
    input  logic signed [DW-1:0]  next_tap,
    output logic signed [DW-1:0]  delay_out,
    output logic signed [DW-1:0]  tap_out
);

    logic signed [DW-1:0] delay_reg  [CHANNELS];
    logic signed [DW-1:0] delay_next [CHANNELS];
    logic signed [DW-1:0] tap_reg;
    logic signed [DW-1:0] tap_next;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            delay_next[c] = delay_reg[c];
            if (ch_sel[c] && ctrl.push)
            begin
                delay_next[c] = prev_delay;
            end
            else if (ch_sel[c] && ctrl.rotate)
            begin
                delay_next[c] = next_delay;
            end
        end
    end

    always_comb
    begin
        tap_next = tap_reg;
        if (ctrl.rotate)
        begin
            tap_next = next_tap;
        end
        else if (tap_we)
        begin
            tap_next = tap_load;
        end
    end

    always_comb
    begin
        delay_out = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            delay_out = delay_out | (delay_reg[c] & {DW{ch_sel[c]}});
        end
    end

    assign tap_out = tap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                delay_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                delay_reg[c] <= delay_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tap_reg <= tap_next;
    end

endmodule

[rtl/fwb_mac.sv]
// Multiply-accumulate unit with bias preload, rounding and saturation to Q1.23.
`timescale 1ns / 1ps

module fwb_mac
    import fwb_pkg::*;
#(
    parameter int TAP_DEPTH = TAP_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  fwb_mac_ctrl_t         ctrl,
    input  logic signed [DW-1:0]  bias,
    input  logic signed [DW-1:0]  tap,
    input  logic signed [DW-1:0]  delay,
    output logic signed [DW-1:0]  result
);

    localparam int ACC_W = PROD_W + 2 + $clog2(TAP_DEPTH);
    localparam int Q_W   = ACC_W - FRAC_W;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [Q_W-1:0]    quot;
    logic signed [DW-1:0]     result_reg;
    logic signed [DW-1:0]     result_next;

    assign prod_next = tap * delay;

    always_comb
    begin
        if (ctrl.start)
        begin
            acc_next = {{(ACC_W-DW-FRAC_W){bias[DW-1]}}, bias, {FRAC_W{1'b0}}};
        end
        else if (prod_valid_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    assign rounded = acc_reg + (ACC_W'(1) <<< (FRAC_W - 1));
    assign quot    = rounded[ACC_W-1:FRAC_W];

    always_comb
    begin
        if (quot > Q_W'(Q_MAX))
        begin
            result_next = DW'(Q_MAX);
        end
        else if (quot < Q_W'(Q_MIN))
        begin
            result_next = DW'(Q_MIN);
        end
        else
        begin
            result_next = quot[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.mult_valid && !ctrl.start;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (ctrl.round_en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

[sim/fir_filter_with_bias_top_test.sv]
// Self-checking testbench of the multi-channel FIR filter with bias, with a predictor.
`timescale 1ns / 1ps

module fir_filter_with_bias_top_test;
    import fwb_pkg::*;

    localparam int TAIL_CYCLES = 300;
    localparam int STALL_LIMIT = 20000;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 110;

    typedef enum logic {
        ROW_CFG,
        ROW_BEAT
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [REG_IDX_W-1:0] cfg_idx;
        logic [DW-1:0]        cfg_val;
        logic                 op;
        logic                 ch;
        logic [DW-1:0]        smp;
        logic [TAP_IDX_W-1:0] tidx;
        logic [DW-1:0]        tval;
        logic                 last;
        logic                 typed;
        logic [DW-1:0]        want;
    } stim_row_t;

    typedef struct packed {
        logic          ch;
        logic [DW-1:0] value;
        logic          last;
    } filt_out_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [IN_USER_W-1:0] s_tuser = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DW-1:0]        m_tdata;
    logic [CH_W-1:0]      m_tuser;
    logic                 m_tlast;
    logic                 cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [DW-1:0]        cfg_data = '0;

    logic signed [DW-1:0]     coeffs [TAP_DEPTH_DEF];
    logic signed [DW-1:0]     history [CHANNELS_DEF][TAP_DEPTH_DEF];
    logic [TAP_IDX_W-1:0]     wr_slot [CHANNELS_DEF];
    logic [TAP_CNT_W-1:0]     taps_in_use;
    logic signed [DW-1:0]     bias_level;

    filt_out_t filtered_queue [$];
    stim_row_t stim_rows [$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        mismatches = 0;
    int        idle_cycles = 0;

    fir_filter_with_bias_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // sample, tap_index, tap_value
        .s_tuser   (s_tuser),     // opcode, channel
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // filtered_sample
        .m_tuser   (m_tuser),     // out_channel
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic filt_out_t predict_filter(logic ch, logic signed [DW-1:0] x, logic last);
        int unsigned          n;
        longint               acc;
        longint               rounded;
        logic [TAP_IDX_W-1:0] pos;
        logic [TAP_IDX_W-1:0] slot;
        filt_out_t            res;
        pos = wr_slot[ch];
        history[ch][pos] = x;
        n = (taps_in_use > TAP_DEPTH_DEF) ? TAP_DEPTH_DEF : taps_in_use;
        acc = longint'(bias_level) <<< FRAC_W;
        for (int unsigned k = 0; k < n; k++)
        begin
            slot = pos - TAP_IDX_W'(k);
            acc += longint'(coeffs[k]) * longint'(history[ch][slot]);
        end
        rounded = (acc + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
        if (rounded > Q_MAX)
            rounded = Q_MAX;
        else if (rounded < Q_MIN)
            rounded = Q_MIN;
        wr_slot[ch] = pos + 1'b1;
        res.ch = ch;
        res.value = rounded[DW-1:0];
        res.last = last;
        return res;
    endfunction

    function automatic logic signed [DW-1:0] rand_q();
        logic signed [DW-1:0] v;
        v = DW'($urandom);
        case ($urandom_range(5))
            0: v = 24'sh7fffff;
            1: v = 24'sh800000;
            2: v = v >>> 9;
            3: v = v >>> 15;
            default: ;
        endcase
        return v;
    endfunction

    task automatic flag_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
        $display("mismatch on %s: got %h, want %h", what, got, want);
        mismatches++;
    endtask

    task automatic settle(int extra);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (filtered_queue.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DW-1:0] val);
        settle(TAIL_CYCLES);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TAP_COUNT)
            taps_in_use = val[TAP_CNT_W-1:0];
        else
            bias_level = val;
    endtask

    task automatic push_beat(logic op, logic ch, logic [DW-1:0] smp, logic [TAP_IDX_W-1:0] tidx,
                             logic [DW-1:0] tval, logic last, logic typed, logic [DW-1:0] want);
        filt_out_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {tval, tidx, smp};
        s_tuser <= {ch, op};
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == OP_LOAD)
        begin
            coeffs[tidx] = tval;
        end
        else
        begin
            res = predict_filter(ch, smp, last);
            if (typed)
                res.value = want;
            filtered_queue.push_back(res);
        end
    endtask

    task automatic add_cfg(logic [REG_IDX_W-1:0] idx, logic [DW-1:0] val);
        stim_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.cfg_idx = idx;
        r.cfg_val = val;
        stim_rows.push_back(r);
    endtask

    task automatic add_beat(logic op, logic ch, logic [DW-1:0] smp, logic [TAP_IDX_W-1:0] tidx,
                            logic [DW-1:0] tval, logic last, logic typed, logic [DW-1:0] want);
        stim_row_t r;
        r = '0;
        r.kind = ROW_BEAT;
        r.op = op;
        r.ch = ch;
        r.smp = smp;
        r.tidx = tidx;
        r.tval = tval;
        r.last = last;
        r.typed = typed;
        r.want = want;
        stim_rows.push_back(r);
    endtask

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        filt_out_t exp_out;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (filtered_queue.size() == 0)
            begin
                flag_mismatch("unexpected beat", m_tdata, '0);
            end
            else
            begin
                exp_out = filtered_queue.pop_front();
                if (m_tuser[0] !== exp_out.ch)
                    flag_mismatch("out_channel", DW'(m_tuser), DW'(exp_out.ch));
                if (m_tdata !== exp_out.value)
                    flag_mismatch("filtered_sample", m_tdata, exp_out.value);
                if (m_tlast !== exp_out.last)
                    flag_mismatch("out_block_end", DW'(m_tlast), DW'(exp_out.last));
            end
        end
    end

    initial
    begin
        @(posedge clk);
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("fir_filter_with_bias_top_test failed");
        $finish;
    end

    initial
    begin
        logic [TAP_CNT_W-1:0] cnt;
        logic [DW-1:0]        bval;
        for (int k = 0; k < TAP_DEPTH_DEF; k++)
        begin
            coeffs[k] = '0;
            history[0][k] = '0;
            history[1][k] = '0;
        end
        wr_slot[0] = '0;
        wr_slot[1] = '0;
        taps_in_use = TAP_COUNT_RST;
        bias_level = '0;

        // Saturation in both directions with four full-scale taps.
        add_cfg(REG_TAP_COUNT, 24'd4);
        add_cfg(REG_BIAS, 24'd0);
        add_beat(OP_LOAD, 1'b1, 24'h5a5a5a, 8'd0, 24'h7fffff, 1'b0, 1'b0, '0);
        add_beat(OP_LOAD, 1'b0, 24'ha5a5a5, 8'd1, 24'h7fffff, 1'b1, 1'b0, '0);
        add_beat(OP_LOAD, 1'b1, 24'hffffff, 8'd2, 24'h7fffff, 1'b0, 1'b0, '0);
        add_beat(OP_LOAD, 1'b0, 24'h000000, 8'd3, 24'h7fffff, 1'b0, 1'b0, '0);
        add_beat(OP_SAMPLE, 1'b0, 24'h7fffff, 8'hff, 24'h800000, 1'b0, 1'b0, '0);
        add_beat(OP_SAMPLE, 1'b0, 24'h7fffff, 8'h00, 24'hffffff, 1'b0, 1'b1, 24'h7fffff);
        add_beat(OP_SAMPLE, 1'b0, 24'h7fffff, 8'h3c, 24'h000000, 1'b1, 1'b1, 24'h7fffff);
        add_beat(OP_SAMPLE, 1'b1, 24'h800000, 8'hc3, 24'h123456, 1'b0, 1'b1, 24'h800001);
        add_beat(OP_SAMPLE, 1'b1, 24'h800000, 8'h00, 24'h000000, 1'b1, 1'b1, 24'h800000);
        // Rounding ties go toward plus infinity with a single unit tap.
        add_beat(OP_LOAD, 1'b0, 24'h000000, 8'd255, 24'h800000, 1'b1, 1'b0, '0);
        add_beat(OP_LOAD, 1'b1, 24'h7fffff, 8'd0, 24'h000001, 1'b0, 1'b0, '0);
        add_cfg(REG_TAP_COUNT, 24'd1);
        add_beat(OP_SAMPLE, 1'b0, 24'h400000, 8'h00, 24'h000000, 1'b0, 1'b1, 24'h000001);
        add_beat(OP_SAMPLE, 1'b1, 24'hc00000, 8'h00, 24'h000000, 1'b1, 1'b1, 24'h000000);
        add_beat(OP_SAMPLE, 1'b0, 24'h000000, 8'hff, 24'hffffff, 1'b0, 1'b1, 24'h000000);
        // With no taps in use the output is the bias alone.
        add_cfg(REG_TAP_COUNT, 24'd0);
        add_cfg(REG_BIAS, 24'h7fffff);
        add_beat(OP_SAMPLE, 1'b0, 24'h800000, 8'h00, 24'h000000, 1'b0, 1'b1, 24'h7fffff);
        add_cfg(REG_BIAS, 24'h800000);
        add_beat(OP_SAMPLE, 1'b1, 24'h7fffff, 8'h00, 24'h000000, 1'b1, 1'b1, 24'h800000);
        add_cfg(REG_TAP_COUNT, 24'd2);
        add_cfg(REG_BIAS, 24'h123456);
        add_beat(OP_SAMPLE, 1'b0, 24'h654321, 8'h00, 24'h000000, 1'b0, 1'b0, '0);
        add_beat(OP_SAMPLE, 1'b1, 24'h9abcde, 8'h00, 24'h000000, 1'b1, 1'b0, '0);

        send_idle_pct = 34;
        recv_idle_pct = 76;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_CFG)
                write_reg(stim_rows[i].cfg_idx, stim_rows[i].cfg_val);
            else
                push_beat(stim_rows[i].op, stim_rows[i].ch, stim_rows[i].smp,
                          stim_rows[i].tidx, stim_rows[i].tval, stim_rows[i].last,
                          stim_rows[i].typed, stim_rows[i].want);
        end

        // Every tap gets a value before the full tap count is used.
        for (int k = 0; k < TAP_DEPTH_DEF; k++)
            push_beat(OP_LOAD, 1'($urandom), rand_q(), TAP_IDX_W'(k), rand_q(),
                      1'($urandom), 1'b0, '0);

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0: begin cnt = 9'd256; bval = 24'd0; end
                1: begin cnt = 9'd1; bval = 24'h7fffff; end
                2: begin cnt = TAP_CNT_W'($urandom_range(1, 256)); bval = rand_q(); end
                3: begin cnt = 9'd511; bval = 24'h800000; end
                4: begin cnt = 9'd0; bval = rand_q(); end
                default: begin cnt = TAP_CNT_W'($urandom_range(2, 32)); bval = rand_q() >>> 6; end
            endcase
            send_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 76 : 0;
            recv_idle_pct = (ph < 2) ? 76 : (ph < 4) ? 34 : 0;
            write_reg(REG_TAP_COUNT, DW'(cnt));
            write_reg(REG_BIAS, bval);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(99) < 3)
                    settle(0);
                if ($urandom_range(99) < 15)
                    push_beat(OP_LOAD, 1'($urandom), rand_q(), TAP_IDX_W'($urandom), rand_q(),
                              1'($urandom), 1'b0, '0);
                else
                    push_beat(OP_SAMPLE, 1'($urandom), rand_q(), TAP_IDX_W'($urandom), rand_q(),
                              ($urandom_range(3) == 0), 1'b0, '0);
            end
        end

        settle(TAIL_CYCLES);
        if (mismatches == 0)
            $display("fir_filter_with_bias_top_test passed");
        else
            $display("fir_filter_with_bias_top_test failed");
        $finish;
    end

endmodule
